>>> rtl/axis_rotate_about_center_macros.svh
// Assertion macros for the axis rotate-about-center block and its checker.
`ifndef AXIS_ROTATE_ABOUT_CENTER_MACROS_SVH
`define AXIS_ROTATE_ABOUT_CENTER_MACROS_SVH

// same-cycle implication
`define ARC_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("arc check failed");

// next-cycle implication
`define ARC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("arc check failed");

`endif

>>> rtl/arc_pkg.sv
// Types, constants, trig table and helpers for the axis rotate-about-center block.
package arc_pkg;

    localparam int COORD_BITS = 32;
    localparam int STEP_BITS  = 8;
    localparam int TRIG_BITS  = 32;
    localparam int TRIG_SHIFT = 30;
    localparam int TRIG_DEPTH = (1 << (STEP_BITS - 1)) + 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + TRIG_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;
    localparam int RND_BITS   = SUM_BITS - TRIG_SHIFT;
    localparam int WIDE_BITS  = 2 * TRIG_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic signed [RND_BITS-1:0]   rnd_t;
    typedef logic signed [RND_BITS:0]     osum_t;
    typedef logic signed [TRIG_BITS-1:0]  trig_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic signed [STEP_BITS-1:0]  step_t;

    typedef enum logic [1:0] {
        CMD_X    = 2'd0,
        CMD_Y    = 2'd1,
        CMD_Z    = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    localparam trig_t  TRIG_ONE  = trig_t'(1) <<< TRIG_SHIFT;
    localparam trig_t  COS_STEP  = trig_t'(1068377587);
    localparam trig_t  SIN_STEP  = trig_t'(107195315);
    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        trig_t c;
        trig_t s;
    } cs_t;

    typedef cs_t [TRIG_DEPTH-1:0] cs_tab_t;

    typedef struct packed {
        cmd_t   cmd;
        coord_t px;
        coord_t py;
        coord_t pz;
        coord_t cx;
        coord_t cy;
        coord_t cz;
        step_t  steps;
    } arc_in_t;

    typedef struct packed {
        cmd_t   cmd;
        coord_t cu;
        coord_t cv;
        coord_t w;
        diff_t  du;
        diff_t  dv;
        trig_t  c;
        trig_t  s;
    } st1_t;

    typedef struct packed {
        cmd_t   cmd;
        coord_t cu;
        coord_t cv;
        coord_t w;
        prod_t  p_uc;
        prod_t  p_vs;
        prod_t  p_vc;
        prod_t  p_us;
    } st2_t;

    typedef struct packed {
        cmd_t   cmd;
        coord_t cu;
        coord_t cv;
        coord_t w;
        rnd_t   ru;
        rnd_t   rv;
    } st3_t;

    // cos/sin of n steps, each entry one rounded rotation of the previous one
    function automatic cs_tab_t build_cs_tab();
        cs_tab_t tab;
        trig_t   c;
        trig_t   s;
        wide_t   pc;
        wide_t   ps;
        wide_t   half;
        c    = TRIG_ONE;
        s    = '0;
        half = wide_t'(1) <<< (TRIG_SHIFT - 1);
        for (int i = 0; i < TRIG_DEPTH; i++) begin
            tab[i].c = c;
            tab[i].s = s;
            pc = (wide_t'(c) * wide_t'(COS_STEP)) - (wide_t'(s) * wide_t'(SIN_STEP));
            ps = (wide_t'(s) * wide_t'(COS_STEP)) + (wide_t'(c) * wide_t'(SIN_STEP));
            pc = (pc + half) >>> TRIG_SHIFT;
            ps = (ps + half) >>> TRIG_SHIFT;
            c  = pc[TRIG_BITS-1:0];
            s  = ps[TRIG_BITS-1:0];
        end
        return tab;
    endfunction

    localparam cs_tab_t CS_TAB = build_cs_tab();

    function automatic coord_t sat_coord(osum_t v);
        coord_t r;
        if (v > osum_t'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (v < osum_t'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/arc_setup.sv
// Stage 1: trig lookup, axis selection and offset from center.
module arc_setup (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  arc_pkg::arc_in_t in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output arc_pkg::st1_t   out_word
);

    logic                          valid_reg;
    arc_pkg::st1_t                 data_reg;
    arc_pkg::st1_t                 data_next;
    logic [arc_pkg::STEP_BITS-1:0] step_mag;
    arc_pkg::cs_t                  cs;
    arc_pkg::coord_t               u;
    arc_pkg::coord_t               v;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = data_reg;

    always_comb
    begin
        step_mag = in_word.steps[arc_pkg::STEP_BITS-1] ? $unsigned(-in_word.steps)
                                                       : $unsigned(in_word.steps);
        cs = arc_pkg::CS_TAB[step_mag];
        data_next.cmd = in_word.cmd;
        data_next.c   = cs.c;
        data_next.s   = in_word.steps[arc_pkg::STEP_BITS-1] ? -cs.s : cs.s;
        unique case (in_word.cmd)
            arc_pkg::CMD_X:
            begin
                u           = in_word.py;
                v           = in_word.pz;
                data_next.cu = in_word.cy;
                data_next.cv = in_word.cz;
                data_next.w  = in_word.px;
            end
            arc_pkg::CMD_Y:
            begin
                u           = in_word.px;
                v           = in_word.pz;
                data_next.cu = in_word.cx;
                data_next.cv = in_word.cz;
                data_next.w  = in_word.py;
            end
            arc_pkg::CMD_Z, arc_pkg::CMD_NONE:
            begin
                u           = in_word.px;
                v           = in_word.py;
                data_next.cu = in_word.cx;
                data_next.cv = in_word.cy;
                data_next.w  = in_word.pz;
            end
        endcase
        // no rotation: identity trig makes the pair come back unchanged
        if (in_word.cmd == arc_pkg::CMD_NONE) begin
            data_next.c = arc_pkg::TRIG_ONE;
            data_next.s = '0;
        end
        data_next.du = arc_pkg::diff_t'(u) - arc_pkg::diff_t'(data_next.cu);
        data_next.dv = arc_pkg::diff_t'(v) - arc_pkg::diff_t'(data_next.cv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/arc_mul.sv
// Stage 2: the four offset-by-trig products.
module arc_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  arc_pkg::st1_t in_word,
    output logic          out_valid,
    input  logic          out_ready,
    output arc_pkg::st2_t out_word
);

    logic          valid_reg;
    arc_pkg::st2_t data_reg;
    arc_pkg::st2_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = data_reg;

    always_comb
    begin
        data_next.cmd  = in_word.cmd;
        data_next.cu   = in_word.cu;
        data_next.cv   = in_word.cv;
        data_next.w    = in_word.w;
        data_next.p_uc = in_word.du * in_word.c;
        data_next.p_vs = in_word.dv * in_word.s;
        data_next.p_vc = in_word.dv * in_word.c;
        data_next.p_us = in_word.du * in_word.s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/arc_finish.sv
// Stages 3 and 4: sum and round, then recenter, saturate and place on the axes.
module arc_finish (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  arc_pkg::st2_t   in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output arc_pkg::coord_t out_x,
    output arc_pkg::coord_t out_y,
    output arc_pkg::coord_t out_z
);

    localparam arc_pkg::sum_t HALF = arc_pkg::sum_t'(1) <<< (arc_pkg::TRIG_SHIFT - 1);

    logic            rnd_valid_reg;
    logic            rnd_ready;
    arc_pkg::st3_t   rnd_reg;
    arc_pkg::st3_t   rnd_next;
    arc_pkg::sum_t   sum_u;
    arc_pkg::sum_t   sum_v;
    logic            out_valid_reg;
    arc_pkg::coord_t x_reg;
    arc_pkg::coord_t y_reg;
    arc_pkg::coord_t z_reg;
    arc_pkg::coord_t x_next;
    arc_pkg::coord_t y_next;
    arc_pkg::coord_t z_next;
    arc_pkg::coord_t ru_sat;
    arc_pkg::coord_t rv_sat;

    assign rnd_ready = !out_valid_reg || out_ready;
    assign in_ready  = !rnd_valid_reg || rnd_ready;
    assign out_valid = out_valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

    always_comb
    begin
        sum_u = ((arc_pkg::sum_t'(in_word.p_uc) + arc_pkg::sum_t'(in_word.p_vs)) + HALF)
                >>> arc_pkg::TRIG_SHIFT;
        sum_v = ((arc_pkg::sum_t'(in_word.p_vc) - arc_pkg::sum_t'(in_word.p_us)) + HALF)
                >>> arc_pkg::TRIG_SHIFT;
        rnd_next.cmd = in_word.cmd;
        rnd_next.cu  = in_word.cu;
        rnd_next.cv  = in_word.cv;
        rnd_next.w   = in_word.w;
        rnd_next.ru  = sum_u[arc_pkg::RND_BITS-1:0];
        rnd_next.rv  = sum_v[arc_pkg::RND_BITS-1:0];
    end

    always_comb
    begin
        ru_sat = arc_pkg::sat_coord(arc_pkg::osum_t'(rnd_reg.cu) + arc_pkg::osum_t'(rnd_reg.ru));
        rv_sat = arc_pkg::sat_coord(arc_pkg::osum_t'(rnd_reg.cv) + arc_pkg::osum_t'(rnd_reg.rv));
        unique case (rnd_reg.cmd)
            arc_pkg::CMD_X:
            begin
                x_next = rnd_reg.w;
                y_next = ru_sat;
                z_next = rv_sat;
            end
            arc_pkg::CMD_Y:
            begin
                x_next = ru_sat;
                y_next = rnd_reg.w;
                z_next = rv_sat;
            end
            arc_pkg::CMD_Z, arc_pkg::CMD_NONE:
            begin
                x_next = ru_sat;
                y_next = rv_sat;
                z_next = rnd_reg.w;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                rnd_valid_reg <= in_valid;
            end
            if (rnd_ready) begin
                out_valid_reg <= rnd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            rnd_reg <= rnd_next;
        end
        if (rnd_ready && rnd_valid_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

>>> rtl/axis_rotate_about_center.sv
// Top level: rotation of a 3D point about an X, Y or Z axis through a center.
// Input word: command (0 = X, 1 = Y, 2 = Z, 3 = no rotation), point, center and a
// signed count of 0.1 rad steps. Output word: the rotated point, Q16.16, saturated.
// Both channels are valid/ready; a word moves when valid and ready are high together.
// Pipeline of four register stages: trig lookup and offsets, products, sum and
// round, recenter and saturate. Throughput is one word per cycle while out_ready is
// high; every stage holds a valid bit of its own.
// The cos/sin pair for each step count is a 129-entry constant table, so the
// angle is a combinational lookup; the 33x32 products set the depth of stage two.
// When the receiver stalls, the output word holds and stages fill behind it;
// in_ready drops only when all four stages are full.
// Reset clears every valid bit; no word is in flight afterwards.
module axis_rotate_about_center (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      command,
    input  arc_pkg::coord_t point_x,
    input  arc_pkg::coord_t point_y,
    input  arc_pkg::coord_t point_z,
    input  arc_pkg::coord_t center_x,
    input  arc_pkg::coord_t center_y,
    input  arc_pkg::coord_t center_z,
    input  arc_pkg::step_t  turn_steps,
    output logic            out_valid,
    input  logic            out_ready,
    output arc_pkg::coord_t out_x,
    output arc_pkg::coord_t out_y,
    output arc_pkg::coord_t out_z
);

    arc_pkg::arc_in_t in_word;
    arc_pkg::st1_t    s1_word;
    arc_pkg::st2_t    s2_word;
    logic             s1_valid;
    logic             s1_ready;
    logic             s2_valid;
    logic             s2_ready;

    always_comb
    begin
        in_word.cmd   = arc_pkg::cmd_t'(command);
        in_word.px    = point_x;
        in_word.py    = point_y;
        in_word.pz    = point_z;
        in_word.cx    = center_x;
        in_word.cy    = center_y;
        in_word.cz    = center_z;
        in_word.steps = turn_steps;
    end

    arc_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_word  (s1_word)
    );

    arc_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_word   (s1_word),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_word  (s2_word)
    );

    arc_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_word   (s2_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

endmodule

>>> rtl/arc_checker.sv
// Port-level checks for the axis rotate-about-center block, bound to the top level.
`include "axis_rotate_about_center_macros.svh"

module arc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input arc_pkg::coord_t out_x,
    input arc_pkg::coord_t out_y,
    input arc_pkg::coord_t out_z
);

    logic in_acc;
    logic drain;

    assign in_acc = in_valid && in_ready;
    assign drain  = out_ready && !in_acc;

    // stalled output word holds
    `ARC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))

    // an empty output stage means nothing upstream can be blocked
    `ARC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // free output with no new words accepted drains the pipeline, leaving out_valid low
    `ARC_ASSERT_NEXT(a_drain, clk, rst_n, drain ##1 drain ##1 drain ##1 drain, !out_valid)

endmodule

bind axis_rotate_about_center arc_checker u_arc_checker (.*);
